// ===== src/euler_number_bit_quad_top_defines.svh =====
// Assertion macros for the bit-quad Euler number block.
// Included by euler_number_bit_quad_top.sv; no other dependencies.
`ifndef EULER_NUMBER_BIT_QUAD_TOP_DEFINES_SVH
`define EULER_NUMBER_BIT_QUAD_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and active-low reset
`define EBQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same on the block's own clk and rst_n
`define EBQ_ASSERT(lbl, prop, msg) `EBQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define EBQ_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define EBQ_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== src/ebq_pkg.sv =====
// Shared constants and types for the bit-quad Euler number block.
// No dependencies; imported by euler_number_bit_quad_top.
package ebq_pkg;

    // Port widths
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    // Counter and result widths
    localparam int CNT_W   = 20;
    localparam int RES_W   = 20;
    localparam int SUM_W   = 23;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;
    localparam logic                  CONN_EIGHT_RESET  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_CONNECTIVITY = 1'b1
    } cfg_index_t;

    // Per-pixel control carried from the accept stage to the quad stage
    typedef struct packed {
        logic valid;
        logic pixel;
        logic last;
        logic row_end;
        logic count_en;
        logic use_up;
    } quad_ctl_t;

endpackage

// ===== src/euler_number_bit_quad_top.sv =====
// Bit-quad Euler number of a binary mask streamed in raster order.
// Depends on ebq_pkg.sv and euler_number_bit_quad_top_defines.svh.
`include "euler_number_bit_quad_top_defines.svh"

// The block takes one mask pixel per cycle and returns the Euler number of
// the image on the pixel flagged by s_tlast. The previous row lives in a
// MAX_WIDTH x 1 synchronous RAM that is read and written at the current
// column in the cycle a pixel is accepted; the quad is classified and a
// counter bumped in the following cycle. After each end-of-image pixel
// s_tready drops while the final counts move to the result stage, and
// stays low while those counts wait for a busy output register;
// otherwise the sustained rate is one pixel per cycle, and one finished
// result can wait at the output while the next image streams in. The line
// store has no reset and no clearing pass: each row is written before the
// next row reads it.
module euler_number_bit_quad_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Pixel stream; s_tdata bit 0: pixel, upper bits zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ebq_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    // Result stream; m_tdata bits 19:0: Euler number, upper bits zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ebq_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [ebq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ebq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ebq_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (XW + 1 > CFG_DATA_W) ? XW + 1 : CFG_DATA_W;

    // Configuration registers
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic                  conn_eight_reg;

    // Accept stage state
    logic [XW-1:0] col_reg;
    logic          pfr_reg;

    // Quad stage state
    quad_ctl_t        b_reg;
    quad_ctl_t        b_next;
    logic             up_rd_reg;
    logic             ul_reg;
    logic             lf_reg;
    logic [CNT_W-1:0] single_reg;
    logic [CNT_W-1:0] triple_reg;
    logic [CNT_W-1:0] diag_reg;
    logic [CNT_W-1:0] single_next;
    logic [CNT_W-1:0] triple_next;
    logic [CNT_W-1:0] diag_next;

    // Result stage: final counts of a finished image
    logic             c_valid_reg;
    logic             c_conn_reg;
    logic [CNT_W-1:0] c_single_reg;
    logic [CNT_W-1:0] c_triple_reg;
    logic [CNT_W-1:0] c_diag_reg;

    // Output register
    logic             out_valid_reg;
    logic [RES_W-1:0] out_data_reg;
    logic [RES_W-1:0] result_next;

    // Line store
    logic line_mem [MAX_WIDTH];

    logic          accept;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] x_plus;
    logic          up;
    logic [2:0]    ones;
    logic          out_load;

    cfg_index_t cfg_sel;
    assign cfg_sel = cfg_index_t'(cfg_index);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RESET;
            conn_eight_reg  <= CONN_EIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_IMAGE_WIDTH:  image_width_reg <= cfg_wdata;
                REG_CONNECTIVITY: conn_eight_reg  <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Input pauses while a finished image heads for the result stage
    assign s_tready = !(b_reg.valid && b_reg.last) && !c_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Active width: zero acts as one, clamp to the line store depth
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = WW'(1);
        else if (WW'(image_width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width_reg);
    end

    assign x_plus = WW'(col_reg) + WW'(1);

    always_comb
    begin
        b_next          = '0;
        b_next.valid    = accept;
        b_next.pixel    = s_tdata[0];
        b_next.last     = s_tlast;
        b_next.row_end  = (x_plus >= w_eff);
        b_next.count_en = pfr_reg && (col_reg != '0);
        b_next.use_up   = pfr_reg;
    end

    // Line store: read old value and write new pixel at the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg         <= line_mem[col_reg];
            line_mem[col_reg] <= s_tdata[0];
        end
    end

    // Column and row tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            pfr_reg <= 1'b0;
            b_reg   <= '0;
        end
        else
        begin
            b_reg <= b_next;
            if (accept)
            begin
                if (s_tlast)
                begin
                    col_reg <= '0;
                    pfr_reg <= 1'b0;
                end
                else if (b_next.row_end)
                begin
                    col_reg <= '0;
                    pfr_reg <= 1'b1;
                end
                else
                begin
                    col_reg <= x_plus[XW-1:0];
                end
            end
        end
    end

    // Quad classification with saturating counters
    assign up   = b_reg.use_up ? up_rd_reg : 1'b0;
    assign ones = 3'(ul_reg) + 3'(up) + 3'(lf_reg) + 3'(b_reg.pixel);

    always_comb
    begin
        single_next = single_reg;
        triple_next = triple_reg;
        diag_next   = diag_reg;
        if (b_reg.valid && b_reg.count_en)
        begin
            if (ones == 3'd1)
            begin
                if (single_reg != '1)
                    single_next = single_reg + CNT_W'(1);
            end
            else if (ones == 3'd3)
            begin
                if (triple_reg != '1)
                    triple_next = triple_reg + CNT_W'(1);
            end
            else if (ones == 3'd2 && ul_reg == b_reg.pixel)
            begin
                if (diag_reg != '1)
                    diag_next = diag_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_reg     <= 1'b0;
            lf_reg     <= 1'b0;
            single_reg <= '0;
            triple_reg <= '0;
            diag_reg   <= '0;
        end
        else if (b_reg.valid)
        begin
            if (b_reg.last)
            begin
                single_reg <= '0;
                triple_reg <= '0;
                diag_reg   <= '0;
            end
            else
            begin
                single_reg <= single_next;
                triple_reg <= triple_next;
                diag_reg   <= diag_next;
            end
            if (b_reg.last || b_reg.row_end)
            begin
                ul_reg <= 1'b0;
                lf_reg <= 1'b0;
            end
            else
            begin
                ul_reg <= up;
                lf_reg <= b_reg.pixel;
            end
        end
    end

    // Result stage holds the final counts until the output is free
    assign out_load = c_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (b_reg.valid && b_reg.last)
            c_valid_reg <= 1'b1;
        else if (out_load)
            c_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_reg.valid && b_reg.last)
        begin
            c_single_reg <= single_next;
            c_triple_reg <= triple_next;
            c_diag_reg   <= diag_next;
            c_conn_reg   <= conn_eight_reg;
        end
    end

    // (C1 - C3 +/- 2*Cd) / 4, truncated toward zero, then saturated
    always_comb
    begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] d2;
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] q;
        s  = $signed(SUM_W'(c_single_reg)) - $signed(SUM_W'(c_triple_reg));
        d2 = $signed(SUM_W'({c_diag_reg, 1'b0}));
        v  = c_conn_reg ? (s - d2) : (s + d2);
        if (v < 0)
            v = v + SUM_W'(3);
        q = v >>> 2;
        if (q > $signed(SUM_W'({1'b0, {(RES_W-1){1'b1}}})))
            result_next = {1'b0, {(RES_W-1){1'b1}}};
        else if (q < -$signed(SUM_W'({1'b1, {(RES_W-1){1'b0}}})))
            result_next = {1'b1, {(RES_W-1){1'b0}}};
        else
            result_next = q[RES_W-1:0];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

    // Assertions
    `EBQ_ASSERT(a_last_pauses_input, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "input taken right after end of image")
    `EBQ_ASSERT(a_last_reaches_result, (b_reg.valid && b_reg.last) |=> c_valid_reg, "final counts not captured")
    `EBQ_ASSERT(a_row_flag_on_accept, $rose(pfr_reg) |-> $past(accept), "row flag set without a pixel")

endmodule
